// ===== sv/pcxrse_pkg.sv =====
package pcxrse_pkg;

    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 200;
    localparam int MAX_STARS    = 512;

    localparam int CODE_W     = 8;
    localparam int RUN_W      = 6;
    localparam int COLUMN_W   = 9;
    localparam int ROW_W      = 8;
    localparam int SPEED_W    = 4;
    localparam int STAR_IDX_W = 9;
    localparam int STAR_CNT_W = $clog2(MAX_STARS + 1);

    localparam logic [1:0] RUN_MARK = 2'b11;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic clear;
        logic advance;
    } pos_ctl_t;

    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        logic                frame_full;
        logic                at_end;
    } pos_stat_t;

    // Colours 9 to 15 map to speeds 2 to 8, colour 7 to speed 1, all others to 0.
    function automatic logic [SPEED_W-1:0] speed_of(input logic [CODE_W-1:0] colour);
        logic [SPEED_W-1:0] speed;
        case (colour)
            8'd7:    speed = 4'd1;
            8'd9:    speed = 4'd2;
            8'd10:   speed = 4'd3;
            8'd11:   speed = 4'd4;
            8'd12:   speed = 4'd5;
            8'd13:   speed = 4'd6;
            8'd14:   speed = 4'd7;
            8'd15:   speed = 4'd8;
            default: speed = 4'd0;
        endcase
        return speed;
    endfunction

endpackage

// ===== sv/pcxrse_pos_ctr.sv =====
module pcxrse_pos_ctr
    import pcxrse_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  pos_ctl_t  ctl,
    output pos_stat_t stat
);

    logic [COLUMN_W-1:0] column_reg, column_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic                full_reg, full_next;
    logic                col_wrap;
    logic                row_wrap;

    assign col_wrap = (column_reg == COLUMN_W'(FRAME_WIDTH - 1));
    assign row_wrap = (row_reg == ROW_W'(FRAME_HEIGHT - 1));

    always_comb begin
        column_next = column_reg;
        row_next    = row_reg;
        full_next   = full_reg;
        if (ctl.clear) begin
            column_next = '0;
            row_next    = '0;
            full_next   = 1'b0;
        end else if (ctl.advance) begin
            if (col_wrap) begin
                column_next = '0;
                row_next    = row_reg + ROW_W'(1);
                if (row_wrap) begin
                    full_next = 1'b1;
                end
            end else begin
                column_next = column_reg + COLUMN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
            full_reg   <= 1'b0;
        end else begin
            column_reg <= column_next;
            row_reg    <= row_next;
            full_reg   <= full_next;
        end
    end

    assign stat.column     = column_reg;
    assign stat.row        = row_reg;
    assign stat.frame_full = full_reg;
    assign stat.at_end     = col_wrap && row_wrap;

endmodule

// ===== sv/pcx_rle_star_extractor_core.sv =====
// Run-length star extractor for 8-bit PCX pixel data. Each input word is one byte of the
// encoded pixel stream; a byte with both top bits set announces a run whose length is in
// its low six bits, and the following byte is the run's colour. Every nonzero decoded pixel
// leaves as one output word carrying its column, row, colour, speed and ordinal, and the
// last flag marks the final star caused by an input word; stars stop after 512 per frame.
// Pixels advance one per cycle through a single position counter and one output register,
// unless the output side stalls. A run header byte is only stored; a literal byte becomes
// a run of one pixel and a run value byte a run of up to 63 pixels. The input is not
// ready while a run is being expanded. Raising new_image with a byte restarts the frame
// position, the star count and any pending run before that byte is decoded.
module pcx_rle_star_extractor_core
    import pcxrse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CODE_W-1:0]     s_code_byte,
    input  logic                  s_new_image,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COLUMN_W-1:0]   m_star_x,
    output logic [ROW_W-1:0]      m_star_y,
    output logic [CODE_W-1:0]     m_star_colour,
    output logic [SPEED_W-1:0]    m_star_speed,
    output logic [STAR_IDX_W-1:0] m_star_index,
    output logic                  m_last
);

    state_t                state_reg, state_next;
    logic                  awaiting_reg, awaiting_next;
    logic [RUN_W-1:0]      pending_reg, pending_next;
    logic [RUN_W-1:0]      count_reg, count_next;
    logic [CODE_W-1:0]     value_reg, value_next;
    logic [STAR_CNT_W-1:0] stars_reg, stars_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COLUMN_W-1:0]   out_x_reg;
    logic [ROW_W-1:0]      out_y_reg;
    logic [CODE_W-1:0]     out_colour_reg;
    logic [SPEED_W-1:0]    out_speed_reg;
    logic [STAR_IDX_W-1:0] out_index_reg;
    logic                  out_last_reg;

    pos_ctl_t  pos_ctl;
    pos_stat_t pos_stat;

    logic in_accept;
    logic out_free;
    logic emit_want;
    logic load;
    logic last_star;
    logic full_eff;
    logic await_base;
    logic [RUN_W-1:0] pending_base;

    pcxrse_pos_ctr u_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (pos_ctl),
        .stat    (pos_stat)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_free  = !out_valid_reg || m_ready;

    // A star is due when the colour is nonzero and capacity remains. The value is fixed
    // across a run, so the star is the last of its word when the run ends here, the frame
    // fills here, or capacity is reached with this star.
    assign emit_want = (value_reg != '0) && (stars_reg < STAR_CNT_W'(MAX_STARS));
    assign last_star = (count_reg == RUN_W'(1)) || pos_stat.at_end
                    || (stars_reg == STAR_CNT_W'(MAX_STARS - 1));

    assign full_eff     = s_new_image ? 1'b0 : pos_stat.frame_full;
    assign await_base   = s_new_image ? 1'b0 : awaiting_reg;
    assign pending_base = s_new_image ? '0 : pending_reg;

    always_comb begin
        state_next    = state_reg;
        awaiting_next = awaiting_reg;
        pending_next  = pending_reg;
        count_next    = count_reg;
        value_next    = value_reg;
        stars_next    = stars_reg;
        pos_ctl       = '0;
        load          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    pos_ctl.clear = s_new_image;
                    awaiting_next = await_base;
                    pending_next  = pending_base;
                    if (s_new_image) begin
                        stars_next = '0;
                    end
                    if (!full_eff) begin
                        if (await_base) begin
                            value_next    = s_code_byte;
                            count_next    = pending_base;
                            awaiting_next = 1'b0;
                            pending_next  = '0;
                            if (pending_base != '0) begin
                                state_next = ST_RUN;
                            end
                        end else if (s_code_byte[CODE_W-1 -: 2] == RUN_MARK) begin
                            pending_next  = s_code_byte[RUN_W-1:0];
                            awaiting_next = 1'b1;
                        end else begin
                            value_next = s_code_byte;
                            count_next = RUN_W'(1);
                            state_next = ST_RUN;
                        end
                    end
                end
            end
            ST_RUN: begin
                if (!emit_want || out_free) begin
                    pos_ctl.advance = 1'b1;
                    if (emit_want) begin
                        load       = 1'b1;
                        stars_next = stars_reg + STAR_CNT_W'(1);
                    end
                    count_next = count_reg - RUN_W'(1);
                    if ((count_reg == RUN_W'(1)) || pos_stat.at_end) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            awaiting_reg  <= 1'b0;
            pending_reg   <= '0;
            count_reg     <= '0;
            stars_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            awaiting_reg  <= awaiting_next;
            pending_reg   <= pending_next;
            count_reg     <= count_next;
            stars_reg     <= stars_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        if (load) begin
            out_x_reg      <= pos_stat.column;
            out_y_reg      <= pos_stat.row;
            out_colour_reg <= value_reg;
            out_speed_reg  <= speed_of(value_reg);
            out_index_reg  <= stars_reg[STAR_IDX_W-1:0];
            out_last_reg   <= last_star;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_star_x      = out_x_reg;
    assign m_star_y      = out_y_reg;
    assign m_star_colour = out_colour_reg;
    assign m_star_speed  = out_speed_reg;
    assign m_star_index  = out_index_reg;
    assign m_last        = out_last_reg;

    // A run in progress always has at least one pixel left.
    a_run_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (count_reg != '0))
        else $error("run state with zero pixels left");

    // A star that is not the last of its word keeps the run going.
    a_not_last_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !last_star) |=> (state_reg == ST_RUN))
        else $error("run ended after a star not flagged last");

    // A star is never loaded over one still waiting to be taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!out_valid_reg || m_ready))
        else $error("output word overwritten");

    // The star count never passes the capacity.
    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        stars_reg <= STAR_CNT_W'(MAX_STARS))
        else $error("star count beyond capacity");

endmodule
